[hw/rtl/wsd_pkg.sv]
// Shared types and constants for the work-stealing task deque.
// No dependencies; imported by wsd_ctrl and the top level of the block.
package wsd_pkg;

	// Storage geometry
	localparam int DEPTH        = 256;
	localparam int HANDLE_WIDTH = 48;
	localparam int SLOT_W       = $clog2(DEPTH);
	localparam int IDX_W        = $clog2(2 * DEPTH);
	localparam int OCC_W        = $clog2(DEPTH + 1);
	localparam int IDX_MOD      = 2 * DEPTH;

	// Operation codes
	typedef logic [1:0] op_t;
	localparam op_t OP_PUSH  = 2'd0;
	localparam op_t OP_POP   = 2'd1;
	localparam op_t OP_STEAL = 2'd2;

	// Status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [SLOT_W-1:0]       slot_t;
	typedef logic [OCC_W-1:0]        occ_t;
	typedef logic [HANDLE_WIDTH-1:0] handle_t;

	// Input transaction
	typedef struct packed {
		op_t     operation;
		handle_t task_handle;
	} in_item_t;

	// Result transaction
	typedef struct packed {
		handle_t taken_handle;
		status_t status;
		occ_t    occupancy;
	} out_item_t;

	// Memory command from the index controller
	typedef struct packed {
		logic    we;
		slot_t   waddr;
		handle_t wdata;
		logic    re;
		slot_t   raddr;
	} mem_cmd_t;

	// Result information carried alongside the memory read
	typedef struct packed {
		logic    take;
		status_t status;
		occ_t    occupancy;
	} res_info_t;

endpackage

[hw/rtl/wsd_ram.sv]
// Generic single-write, single-read synchronous RAM, registered read data.
// No package dependencies.
module wsd_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next enabled read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/wsd_ctrl.sv]
// Index controller: holds top and bottom indices, decodes each operation
// into a memory command and result information. Depends on wsd_pkg.
module wsd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  wsd_pkg::in_item_t   item,
	output wsd_pkg::mem_cmd_t   cmd,
	output wsd_pkg::res_info_t  info
);
	import wsd_pkg::*;

	idx_t top_q;
	idx_t bottom_q;
	idx_t top_nxt;
	idx_t bottom_nxt;
	occ_t held;
	occ_t held_nxt;
	logic [IDX_W:0] diff;
	logic [IDX_W:0] diff_nxt;

	function automatic idx_t idx_inc(idx_t i);
		return (i == idx_t'(IDX_MOD - 1)) ? '0 : idx_t'(i + 1'b1);
	endfunction

	function automatic idx_t idx_dec(idx_t i);
		return (i == '0) ? idx_t'(IDX_MOD - 1) : idx_t'(i - 1'b1);
	endfunction

	function automatic slot_t slot_of(idx_t i);
		return (i >= idx_t'(DEPTH)) ? slot_t'(i - idx_t'(DEPTH)) : slot_t'(i);
	endfunction

	// Occupancy before the operation, modulo twice the depth
	always_comb begin
		if (bottom_q >= top_q) begin
			diff = {1'b0, bottom_q} - {1'b0, top_q};
		end else begin
			diff = {1'b0, bottom_q} + (IDX_W+1)'(IDX_MOD) - {1'b0, top_q};
		end
		held = occ_t'(diff);
	end

	// Operation decode, then occupancy after the operation
	always_comb begin
		top_nxt     = top_q;
		bottom_nxt  = bottom_q;
		cmd         = '0;
		cmd.wdata   = item.task_handle;
		cmd.waddr   = slot_of(bottom_q);
		info.take   = 1'b0;
		info.status = ST_DONE;
		case (item.operation)
			OP_PUSH: begin
				if (held >= occ_t'(DEPTH)) begin
					info.status = ST_FULL;
				end else begin
					cmd.we     = 1'b1;
					bottom_nxt = idx_inc(bottom_q);
				end
			end
			OP_POP: begin
				if (held == '0) begin
					info.status = ST_EMPTY;
				end else begin
					cmd.re    = 1'b1;
					cmd.raddr = slot_of(idx_dec(bottom_q));
					info.take = 1'b1;
					if (held == occ_t'(1)) begin
						top_nxt = bottom_q;
					end else begin
						bottom_nxt = idx_dec(bottom_q);
					end
				end
			end
			OP_STEAL: begin
				if (held == '0) begin
					info.status = ST_EMPTY;
				end else begin
					cmd.re    = 1'b1;
					cmd.raddr = slot_of(top_q);
					info.take = 1'b1;
					top_nxt   = idx_inc(top_q);
				end
			end
			default: begin
				// undefined code: no change
			end
		endcase
		cmd.we = cmd.we & accept;
		cmd.re = cmd.re & accept;

		if (bottom_nxt >= top_nxt) begin
			diff_nxt = {1'b0, bottom_nxt} - {1'b0, top_nxt};
		end else begin
			diff_nxt = {1'b0, bottom_nxt} + (IDX_W+1)'(IDX_MOD) - {1'b0, top_nxt};
		end
		held_nxt       = occ_t'(diff_nxt);
		info.occupancy = held_nxt;
	end

	// Index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			bottom_q <= '0;
		end else if (accept) begin
			top_q    <= top_nxt;
			bottom_q <= bottom_nxt;
		end
	end

endmodule

[hw/rtl/work_stealing_deque_top.sv]
// Top level of the work-stealing task deque: index controller, entry RAM,
// read stage and output register. Depends on wsd_pkg, wsd_ctrl, wsd_ram.

// The deque takes one push, pop or steal transaction per cycle while the output
// side keeps up, and returns one result per transaction, in order. The entry RAM
// read and the read stage are registered at acceptance; the result then moves
// into the output register when the output side is ready. Indices are updated at
// acceptance, so back-to-back operations on the same entry need no forwarding.
// A push on a full deque is dropped with status full; pop or steal on an empty
// deque returns status empty. The entry RAM needs no clearing after reset.
module work_stealing_deque_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  wsd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output wsd_pkg::out_item_t out_data
);
	import wsd_pkg::*;

	logic      accept;
	logic      out_load;
	mem_cmd_t  cmd;
	res_info_t info;
	handle_t   rdata;

	logic      valid_s1;
	res_info_t info_s1;
	logic      out_valid_q;
	out_item_t out_data_q;

	// Handshake
	assign out_load = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || out_load;
	assign accept   = in_valid && in_ready;

	wsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_data),
		.cmd    (cmd),
		.info   (info)
	);

	wsd_ram #(
		.DEPTH (DEPTH),
		.WIDTH (HANDLE_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (cmd.waddr),
		.wdata (cmd.wdata),
		.re    (cmd.re),
		.raddr (cmd.raddr),
		.rdata (rdata)
	);

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.taken_handle <= info_s1.take ? rdata : '0;
			out_data_q.status       <= info_s1.status;
			out_data_q.occupancy    <= info_s1.occupancy;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A pending read result is never dropped while the output is stalled
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_load |=> valid_s1)
		else $error("read stage lost a transaction");

	// Only a successful pop or steal returns a handle
	a_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_DONE |-> out_data.taken_handle == '0)
		else $error("handle returned with failing status");

	// Occupancy never exceeds the capacity
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.occupancy <= occ_t'(DEPTH))
		else $error("occupancy above capacity");

	// No write and read of the RAM in the same cycle
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.we && cmd.re))
		else $error("RAM written and read by one transaction");

endmodule
